// ===== hdl/per_flow_latest_packet_store_top_macros.svh =====
// Assertion macros for the per-flow latest packet store.
`ifndef PER_FLOW_LATEST_PACKET_STORE_TOP_MACROS_SVH
`define PER_FLOW_LATEST_PACKET_STORE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define PFLP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PFLP_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PFLP_ASSERT(name, prop, msg)
`define PFLP_NEVER(name, cond, msg)
`endif
`endif

// ===== hdl/pflps_pkg.sv =====
// Types and constants shared by the per-flow latest packet store.
package pflps_pkg;

  localparam int APB_ADDR_W = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_PER_OP_MODE    = 1'b0;
  localparam logic REG_DELIVER_DIRECT = 1'b1;

  // Request codes
  localparam logic [2:0] OP_RECEIVE      = 3'd0;
  localparam logic [2:0] OP_TAKE         = 3'd1;
  localparam logic [2:0] OP_QUERY        = 3'd2;
  localparam logic [2:0] OP_SET_STAMP    = 3'd3;
  localparam logic [2:0] OP_RESET_CLIENT = 3'd4;
  localparam logic [2:0] OP_RESET_ALL    = 3'd5;

  // Result status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_STALE      = 3'd1;
  localparam logic [2:0] STS_CONN       = 3'd2;
  localparam logic [2:0] STS_BAD_CLIENT = 3'd3;
  localparam logic [2:0] STS_BAD_OP     = 3'd4;
  localparam logic [2:0] STS_EMPTY      = 3'd5;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } pflps_state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  link_client;
    logic [7:0]  header_client;
    logic [7:0]  operation_index;
    logic [31:0] stamp;
    logic [15:0] payload_handle;
    logic [15:0] packet_length;
    logic [7:0]  instance_number;
  } pflps_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        delivered;
    logic        pending;
    logic [7:0]  out_client;
    logic [7:0]  out_operation;
    logic [31:0] out_stamp;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [7:0]  out_instance;
  } pflps_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] stamp;
    logic [15:0] handle;
    logic [15:0] length;
    logic [7:0]  inst;
  } pflps_slot_t;

endpackage

// ===== hdl/per_flow_latest_packet_store_top.sv =====
// Per-flow latest packet store: freshness filter with one slot per client and operation.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid_i/ready_o | pflps_in_t  (request or received packet)
//   out     | out_valid_o/ready_i| pflps_out_t (one result per item)
//   cfg     | APB psel/penable   | per_operation_mode, deliver_direct
//
// A receive, take, query or set-stamp item reads its slot from the slot memory
// as it is accepted; in S_EXEC the slot is modified and written back and the
// output register is loaded. The single memory port pair sets this.
// Reset-client first clears the client's NUM_OPERATIONS slots and reset-all all
// (NUM_CLIENTS + 1) * NUM_OPERATIONS slots: one slot is cleared a cycle.
// After reset a clearing pass over all (NUM_CLIENTS + 1) * NUM_OPERATIONS slots
// runs before the first item is accepted; configuration writes are taken.
// A stalled output holds the finished item; the next item is accepted meanwhile
// and waits in the write-back cycle until the output register frees up.
`include "per_flow_latest_packet_store_top_macros.svh"

module per_flow_latest_packet_store_top
  import pflps_pkg::*;
#(
  parameter int NUM_CLIENTS    = 16,
  parameter int NUM_OPERATIONS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pflps_in_t             in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pflps_out_t            out_data_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SLOT_COUNT = (NUM_CLIENTS + 1) * NUM_OPERATIONS;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int IDXF_W     = 17;  // holds 256 * 256
  localparam int SLOT_W     = $bits(pflps_slot_t);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic per_op_q, per_op_d;
  logic direct_q, direct_d;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    per_op_d = per_op_q;
    direct_d = direct_q;
    if (cfg_we) begin
      unique case (paddr[2])
        REG_PER_OP_MODE:    per_op_d = pwdata[0];
        REG_DELIVER_DIRECT: direct_d = pwdata[0];
        default: ;
      endcase
    end
  end

  // Low address bits are the byte offset inside a register
  assign prdata = {31'b0, (paddr[2] == REG_DELIVER_DIRECT) ? direct_q : per_op_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_op_q <= 1'b0;
      direct_q <= 1'b0;
    end else begin
      per_op_q <= per_op_d;
      direct_q <= direct_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode at accept
  // ---------------------------------------------------------------------------
  pflps_state_e state_q, state_d;

  logic              in_acc;
  logic [7:0]        client_w;
  logic [7:0]        oper_w;
  logic              client_ok;
  logic              oper_ok;
  logic [IDXF_W-1:0] base_w;
  logic [IDXF_W-1:0] slot_w;
  logic [IDXF_W-1:0] last_w;
  logic [2:0]        pre_status_d;
  logic              use_mem_d;
  logic              zero_ids_d;
  logic              sweep_all_d;
  logic              sweep_client_d;

  assign in_acc    = in_valid_i && in_ready_o;
  assign client_w  = (in_data_i.link_client != 8'd0) ? in_data_i.link_client
                                                     : in_data_i.header_client;
  assign oper_w    = per_op_q ? in_data_i.operation_index : 8'd0;
  assign client_ok = {1'b0, client_w} <= 9'(NUM_CLIENTS);
  assign oper_ok   = {1'b0, oper_w} < 9'(NUM_OPERATIONS);
  assign base_w    = IDXF_W'(client_w) * IDXF_W'(NUM_OPERATIONS);
  assign slot_w    = base_w + IDXF_W'(oper_w);
  assign last_w    = base_w + IDXF_W'(NUM_OPERATIONS - 1);

  always_comb begin
    pre_status_d   = STS_OK;
    use_mem_d      = 1'b0;
    zero_ids_d     = 1'b0;
    sweep_all_d    = 1'b0;
    sweep_client_d = 1'b0;
    priority if (in_data_i.operation > OP_RESET_ALL) begin
      pre_status_d = STS_BAD_OP;
      zero_ids_d   = 1'b1;
    end else if (in_data_i.operation == OP_RESET_ALL) begin
      zero_ids_d  = 1'b1;
      sweep_all_d = 1'b1;
    end else if (in_data_i.operation == OP_RECEIVE && in_data_i.stamp == 32'd0) begin
      pre_status_d = STS_CONN;
    end else if (!client_ok) begin
      pre_status_d = STS_BAD_CLIENT;
    end else if (in_data_i.operation == OP_RESET_CLIENT) begin
      sweep_client_d = 1'b1;
    end else if (!oper_ok) begin
      pre_status_d = STS_BAD_OP;
    end else begin
      use_mem_d = 1'b1;
    end
  end

  // Registered request
  pflps_in_t        req_q;
  logic [7:0]       client_q;
  logic [7:0]       oper_q;
  logic [IDX_W-1:0] idx_q;
  logic [2:0]       pre_status_q;
  logic             use_mem_q;
  logic             zero_ids_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q        <= in_data_i;
      client_q     <= client_w;
      // a client reset reports operation 0 in its result
      oper_q       <= sweep_client_d ? 8'd0 : oper_w;
      idx_q        <= slot_w[IDX_W-1:0];
      pre_status_q <= pre_status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_mem_q  <= 1'b0;
      zero_ids_q <= 1'b0;
    end else if (in_acc) begin
      use_mem_q  <= use_mem_d;
      zero_ids_q <= zero_ids_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep: after reset, reset-all and reset-client
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] sweep_addr_q, sweep_addr_d;
  logic [IDX_W-1:0] sweep_end_q, sweep_end_d;
  logic             sweep_res_q, sweep_res_d;
  logic             sweep_last;

  assign sweep_last = sweep_addr_q == sweep_end_q;

  always_comb begin
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    sweep_res_d  = sweep_res_q;
    if (state_q == S_CLEAR && !sweep_last) begin
      sweep_addr_d = sweep_addr_q + IDX_W'(1);
    end
    if (in_acc && sweep_all_d) begin
      sweep_addr_d = '0;
      sweep_end_d  = IDX_W'(SLOT_COUNT - 1);
      sweep_res_d  = 1'b1;
    end else if (in_acc && sweep_client_d) begin
      sweep_addr_d = base_w[IDX_W-1:0];
      sweep_end_d  = last_w[IDX_W-1:0];
      sweep_res_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      sweep_end_q  <= IDX_W'(SLOT_COUNT - 1);
      sweep_res_q  <= 1'b0;
    end else begin
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      sweep_res_q  <= sweep_res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] mem_q [SLOT_COUNT];
  pflps_slot_t       rd_q;
  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  pflps_slot_t       mem_wd;

  assign mem_re = in_acc && use_mem_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= pflps_slot_t'(mem_q[slot_w[IDX_W-1:0]]);
    end
  end

  // ---------------------------------------------------------------------------
  // Modify: result and write-back word from the slot read
  // ---------------------------------------------------------------------------
  logic        out_valid_q, out_valid_d;
  pflps_out_t  out_data_q;
  logic        out_free;
  logic        newer;
  logic        wrap;
  logic        fresh;
  logic [31:0] gap;
  pflps_out_t  res;
  logic        wb_need;
  pflps_slot_t wb_data;

  assign out_free = !out_valid_q || out_ready_i;
  assign newer    = req_q.stamp > rd_q.stamp;
  assign gap      = rd_q.stamp - req_q.stamp;
  assign wrap     = !newer && (gap > (rd_q.stamp >> 1));
  assign fresh    = newer || wrap;

  always_comb begin
    res               = '0;
    res.status        = pre_status_q;
    res.out_client    = zero_ids_q ? 8'd0 : client_q;
    res.out_operation = zero_ids_q ? 8'd0 : oper_q;
    wb_need           = 1'b0;
    wb_data           = rd_q;
    if (use_mem_q) begin
      res.status    = STS_OK;
      res.out_stamp = rd_q.stamp;
      res.pending   = rd_q.valid;
      unique case (req_q.operation)
        OP_RECEIVE: begin
          if (!fresh) begin
            res.status = STS_STALE;
          end else if (direct_q) begin
            // emit at once; a wrapped slot restarts its stamp at zero
            res.delivered    = 1'b1;
            res.out_stamp    = req_q.stamp;
            res.out_handle   = req_q.payload_handle;
            res.out_length   = req_q.packet_length;
            res.out_instance = req_q.instance_number;
            wb_need          = wrap;
            wb_data.stamp    = 32'd0;
          end else begin
            res.out_stamp  = req_q.stamp;
            res.pending    = 1'b1;
            wb_need        = 1'b1;
            wb_data.valid  = 1'b1;
            wb_data.stamp  = req_q.stamp;
            wb_data.handle = req_q.payload_handle;
            wb_data.length = req_q.packet_length;
            wb_data.inst   = req_q.instance_number;
          end
        end
        OP_TAKE: begin
          res.pending = 1'b0;
          if (rd_q.valid) begin
            res.delivered    = 1'b1;
            res.out_handle   = rd_q.handle;
            res.out_length   = rd_q.length;
            res.out_instance = rd_q.inst;
            wb_need          = 1'b1;
            wb_data.valid    = 1'b0;
          end else begin
            res.status = STS_EMPTY;
          end
        end
        OP_QUERY: ;
        OP_SET_STAMP: begin
          res.out_stamp = req_q.stamp;
          wb_need       = 1'b1;
          wb_data.stamp = req_q.stamp;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control: next state and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sweep_last) begin
          state_d = sweep_res_q ? S_EXEC : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (sweep_all_d || sweep_client_d) ? S_CLEAR : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = wb_data;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sweep_addr_q;
        mem_wd = '0;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_EXEC: begin
        if (out_free) begin
          mem_we      = wb_need;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the finished item until taken
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && out_free) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PFLP_NEVER(a_sweep_in_range, state_q == S_CLEAR && sweep_addr_q > sweep_end_q, "sweep past end")
  `PFLP_ASSERT(a_accept_leaves_idle, in_acc |=> state_q != S_IDLE, "accepted item not worked on")
  `PFLP_ASSERT(a_exec_loads_out, state_q == S_EXEC && out_free |=> out_valid_q, "result lost")
  `PFLP_NEVER(a_deliver_only_ok, out_valid_o && out_data_o.delivered && out_data_o.status != STS_OK, "delivery with error status")
  `PFLP_NEVER(a_error_not_pending, out_valid_o && out_data_o.pending && (out_data_o.status == STS_BAD_CLIENT || out_data_o.status == STS_BAD_OP || out_data_o.status == STS_CONN), "pending on error")

endmodule
